// ===== rtl/core/x64ilb_pkg.sv =====
// package for the x86-64 instruction length boundary core
// holds the parse state, result item layout and decode constants
// no dependencies
package x64ilb_pkg;

   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_OP2    = 3'd1,
      PH_MODRM  = 3'd2,
      PH_SIB    = 3'd3,
      PH_TAIL   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN  = 2'd0,
      ST_OK   = 2'd1,
      ST_FAIL = 2'd2
   } status_type;

   typedef struct packed {
      phase_type  phase;
      logic [4:0] pos;
      logic [4:0] len;
      logic       rex_w;
      logic [7:0] modrm;
      logic [3:0] remaining;
      logic [2:0] trail_imm;
      logic       cur_safe;
      logic       all_safe;
      logic [4:0] count;
      status_type status;
   } parse_state_type;

   typedef struct packed {
      logic       is_summary;
      logic [4:0] overwrite_bytes;
      logic [3:0] instr_total;
      logic       plan_reloc_safe;
      logic       decode_ok;
      logic       instr_reloc_safe;
      logic [4:0] instr_length;
   } result_item_type;

   localparam parse_state_type CLEAR_STATE = '{
      phase:     PH_PREFIX,
      pos:       5'd0,
      len:       5'd0,
      rex_w:     1'b0,
      modrm:     8'd0,
      remaining: 4'd0,
      trail_imm: 3'd0,
      cur_safe:  1'b1,
      all_safe:  1'b1,
      count:     5'd0,
      status:    ST_RUN
   };

   localparam result_item_type EMPTY_RESULT = '0;

   localparam logic [4:0] COVER_RESET = 5'd12;

   // result queue depth, a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // opcode and field constants
   localparam logic [7:0] OP_REX_LO  = 8'h40;
   localparam logic [7:0] OP_REX_HI  = 8'h4F;
   localparam logic [7:0] REX_W_MASK = 8'h08;
   localparam logic [7:0] OP_ESCAPE  = 8'h0F;
   localparam logic [7:0] OP_CALL32  = 8'hE8;
   localparam logic [7:0] OP_JMP32   = 8'hE9;
   localparam logic [7:0] OP_JMP8    = 8'hEB;
   localparam logic [7:0] OP_JCC8_LO = 8'h70;
   localparam logic [7:0] OP_JCC8_HI = 8'h7F;
   localparam logic [7:0] OP_MOVI_LO = 8'hB8;
   localparam logic [7:0] OP_MOVI_HI = 8'hBF;
   localparam logic [7:0] OP_PUSH32  = 8'h68;
   localparam logic [7:0] OP_PUSH8   = 8'h6A;
   localparam logic [7:0] OP2_JCC_LO = 8'h80;
   localparam logic [7:0] OP2_JCC_HI = 8'h8F;
   localparam logic [7:0] OP2_NOPM   = 8'h1F;
   localparam logic [1:0] MOD_IND    = 2'd0;
   localparam logic [1:0] MOD_D8     = 2'd1;
   localparam logic [1:0] MOD_D32    = 2'd2;
   localparam logic [1:0] MOD_REG    = 2'd3;
   localparam logic [2:0] RM_SIB     = 3'd4;
   localparam logic [2:0] RM_DISP32  = 3'd5;

endpackage

// ===== rtl/core/x64ilb_decoder.sv =====
// per-byte decode step: parse state and one code byte in, next state and results out
// depends on x64ilb_pkg
module x64ilb_decoder #(
   parameter int WINDOW_BYTES     = 16,
   parameter int MAX_INSTRUCTIONS = 8
) (
   input  x64ilb_pkg::parse_state_type cur_state,
   input  logic [4:0]                  min_cover,
   input  logic [7:0]                  code_byte,
   input  logic                        win_first,
   input  logic                        win_last,
   output x64ilb_pkg::parse_state_type next_state,
   output logic [1:0]                  push_valid,
   output x64ilb_pkg::result_item_type push_item [2]
);
   import x64ilb_pkg::*;

   localparam int POS_LIMIT = (WINDOW_BYTES < 31) ? WINDOW_BYTES : 31;

   always_comb begin
      parse_state_type s;
      result_item_type instr_res;
      result_item_type sum_res;
      logic            done;
      logic            want_tail;
      logic [3:0]      tail_count;
      logic [2:0]      disp;
      logic            ok;

      s          = win_first ? CLEAR_STATE : cur_state;
      done       = 1'b0;
      want_tail  = 1'b0;
      tail_count = 4'd0;
      disp       = 3'd0;
      instr_res  = EMPTY_RESULT;
      sum_res    = EMPTY_RESULT;

      if (s.status == ST_RUN && s.pos < 5'(POS_LIMIT)) begin
         // at an instruction boundary: check cover, then instruction budget
         if (s.phase == PH_PREFIX && s.len == 5'd0) begin
            if (s.pos >= min_cover)
               s.status = ST_OK;
            else if (s.count >= 5'(MAX_INSTRUCTIONS))
               s.status = ST_FAIL;
         end
         if (s.status == ST_RUN) begin
            s.pos = s.pos + 5'd1;
            s.len = s.len + 5'd1;
            unique case (s.phase)
               PH_PREFIX: begin
                  unique case (code_byte) inside
                     [OP_REX_LO:OP_REX_HI]:
                        s.rex_w = |(code_byte & REX_W_MASK);
                     8'h66, 8'h67, 8'hF2, 8'hF3:
                        s.rex_w = 1'b0;
                     [8'h50:8'h5F], 8'h90, 8'hC3, 8'hCC:
                        done = 1'b1;
                     OP_PUSH32: begin
                        want_tail  = 1'b1;
                        tail_count = 4'd4;
                     end
                     OP_PUSH8: begin
                        want_tail  = 1'b1;
                        tail_count = 4'd1;
                     end
                     OP_CALL32, OP_JMP32: begin
                        s.cur_safe = 1'b0;
                        want_tail  = 1'b1;
                        tail_count = 4'd4;
                     end
                     OP_JMP8, [OP_JCC8_LO:OP_JCC8_HI]: begin
                        s.cur_safe = 1'b0;
                        want_tail  = 1'b1;
                        tail_count = 4'd1;
                     end
                     OP_ESCAPE:
                        s.phase = PH_OP2;
                     [OP_MOVI_LO:OP_MOVI_HI]: begin
                        want_tail  = 1'b1;
                        tail_count = s.rex_w ? 4'd8 : 4'd4;
                     end
                     8'h01, 8'h03, 8'h21, 8'h23, 8'h29, 8'h2B, 8'h31, 8'h33, 8'h39,
                     8'h3B, 8'h63, 8'h85, 8'h87, 8'h89, 8'h8B, 8'h8D, 8'hFF: begin
                        s.trail_imm = 3'd0;
                        s.phase     = PH_MODRM;
                     end
                     8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6: begin
                        s.trail_imm = 3'd1;
                        s.phase     = PH_MODRM;
                     end
                     8'h81, 8'h69, 8'hC7: begin
                        s.trail_imm = 3'd4;
                        s.phase     = PH_MODRM;
                     end
                     default:
                        s.status = ST_FAIL;
                  endcase
               end
               PH_OP2: begin
                  if (code_byte >= OP2_JCC_LO && code_byte <= OP2_JCC_HI) begin
                     s.cur_safe = 1'b0;
                     want_tail  = 1'b1;
                     tail_count = 4'd4;
                  end else if (code_byte == OP2_NOPM) begin
                     s.trail_imm = 3'd0;
                     s.phase     = PH_MODRM;
                  end else begin
                     s.status = ST_FAIL;
                  end
               end
               PH_MODRM: begin
                  s.modrm = code_byte;
                  if (code_byte[7:6] != MOD_REG && code_byte[2:0] == RM_SIB) begin
                     s.phase = PH_SIB;
                  end else begin
                     // rip-relative operand makes the copy unsafe
                     if (code_byte[7:6] == MOD_IND && code_byte[2:0] == RM_DISP32) begin
                        s.cur_safe = 1'b0;
                        disp       = 3'd4;
                     end else if (code_byte[7:6] == MOD_D8) begin
                        disp = 3'd1;
                     end else if (code_byte[7:6] == MOD_D32) begin
                        disp = 3'd4;
                     end
                     want_tail  = 1'b1;
                     tail_count = {1'b0, disp} + {1'b0, s.trail_imm};
                  end
               end
               PH_SIB: begin
                  if (s.modrm[7:6] == MOD_IND && code_byte[2:0] == RM_DISP32)
                     disp = 3'd4;
                  else if (s.modrm[7:6] == MOD_D8)
                     disp = 3'd1;
                  else if (s.modrm[7:6] == MOD_D32)
                     disp = 3'd4;
                  want_tail  = 1'b1;
                  tail_count = {1'b0, disp} + {1'b0, s.trail_imm};
               end
               default: begin
                  if (s.remaining != 4'd0)
                     s.remaining = s.remaining - 4'd1;
                  done = (s.remaining == 4'd0);
               end
            endcase

            if (want_tail) begin
               if (tail_count == 4'd0) begin
                  done = 1'b1;
               end else begin
                  s.phase     = PH_TAIL;
                  s.remaining = tail_count;
               end
            end

            if (done) begin
               instr_res.instr_length     = s.len;
               instr_res.instr_reloc_safe = s.cur_safe;
               if (!s.cur_safe)
                  s.all_safe = 1'b0;
               if (s.count != 5'd31)
                  s.count = s.count + 5'd1;
               s.phase     = PH_PREFIX;
               s.len       = 5'd0;
               s.rex_w     = 1'b0;
               s.modrm     = 8'd0;
               s.remaining = 4'd0;
               s.trail_imm = 3'd0;
               s.cur_safe  = 1'b1;
            end
         end
      end

      ok = s.status != ST_FAIL && s.phase == PH_PREFIX && s.len == 5'd0
           && s.pos >= min_cover;
      sum_res.is_summary      = 1'b1;
      sum_res.decode_ok       = ok;
      sum_res.plan_reloc_safe = ok && s.all_safe;
      sum_res.instr_total     = (s.count > 5'd15) ? 4'd15 : s.count[3:0];
      sum_res.overwrite_bytes = ok ? s.pos : 5'd0;

      // results go out packed from slot 0
      push_valid  = {done && win_last, done || win_last};
      push_item[0] = done ? instr_res : sum_res;
      push_item[1] = sum_res;

      next_state = win_last ? CLEAR_STATE : s;
   end

endmodule

// ===== rtl/core/x64ilb_result_queue.sv =====
// small result queue, takes up to two items per cycle and hands out one
// depends on x64ilb_pkg
module x64ilb_result_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  push_valid,
   input  x64ilb_pkg::result_item_type push_item [2],
   output logic                        room_two,
   output logic                        out_valid,
   input  logic                        out_ready,
   output x64ilb_pkg::result_item_type out_item
);
   import x64ilb_pkg::*;

   result_item_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    head_ff, head_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic [QUEUE_AW-1:0]    tail;
   logic                   pop;
   logic [QUEUE_AW:0]      push_n;

   assign tail      = head_ff + count_ff[QUEUE_AW-1:0];
   assign pop       = out_valid && out_ready;
   assign push_n    = (QUEUE_AW+1)'(push_valid[0]) + (QUEUE_AW+1)'(push_valid[1]);
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[head_ff];
   assign room_two  = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
   assign head_in   = pop ? head_ff + 1'b1 : head_ff;
   assign count_in  = count_ff + push_n - (QUEUE_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid[0])
         entry_ff[tail] <= push_item[0];
      if (push_valid[1])
         entry_ff[tail + 1'b1] <= push_item[1];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_no_gap_push: assert property (@(posedge clock) disable iff (reset)
      push_valid[1] |-> push_valid[0])
      else $error("second result slot used without the first");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push_valid == 2'b11 && !pop) |=> count_ff == $past(count_ff) + 2'd2)
      else $error("queue count lost a double push");

endmodule

// ===== rtl/core/x64_instruction_length_boundary_core.sv =====
// top level of the x86-64 instruction length boundary core
// depends on x64ilb_pkg, x64ilb_decoder and x64ilb_result_queue
//
// usage:
//   req channel carries one code byte per item; req_tuser marks the first byte
//   of a window (parse state is cleared before the byte is used) and req_tlast
//   the final byte, after which a window summary item follows.
//   rsp channel gives one item per completed instruction (length, copy-safe
//   flag) and, with rsp_tlast high, the window summary (decode ok, plan safe,
//   instruction count, overwrite length). a byte gives zero, one or two items.
//   csr channel writes min_cover_bytes; it is always ready and should only be
//   written while no item is in flight.
// timing:
//   one byte is decoded per cycle by a single combinational step off the parse
//   state registers; results are written into a four-entry queue and shown on
//   rsp from its head. sustained rate is one byte per cycle as long as results
//   are drained; the queue drain of one item per cycle sets the limit when a
//   byte yields two items.
// reset: parse state cleared, min_cover_bytes back to 12, queue emptied.
// stall: req_tready drops while the queue has fewer than two free entries.
module x64_instruction_length_boundary_core #(
   parameter int WINDOW_BYTES     = 16,
   parameter int MAX_INSTRUCTIONS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code_byte
   input  logic        req_tuser,   // window_first
   input  logic        req_tlast,   // window_last
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] instr_length, [5] instr_reloc_safe, [6] decode_ok,
   // [7] plan_reloc_safe, [11:8] instr_total, [16:12] overwrite_bytes, rest zero
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,   // is_summary
   // min_cover_bytes register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   import x64ilb_pkg::*;

   localparam int POS_LIMIT = (WINDOW_BYTES < 31) ? WINDOW_BYTES : 31;

   parse_state_type state_ff, state_in;
   parse_state_type step_state;
   logic [4:0]      cover_ff, cover_in;
   logic [1:0]      step_valid;
   result_item_type step_item [2];
   logic [1:0]      push_valid;
   logic            room_two;
   logic            accept;
   result_item_type head_item;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = room_two;
   assign csr_ready  = 1'b1;

   // one decode step per accepted byte
   x64ilb_decoder #(
      .WINDOW_BYTES     (WINDOW_BYTES),
      .MAX_INSTRUCTIONS (MAX_INSTRUCTIONS)
   ) u_decoder (
      .cur_state  (state_ff),
      .min_cover  (cover_ff),
      .code_byte  (req_tdata),
      .win_first  (req_tuser),
      .win_last   (req_tlast),
      .next_state (step_state),
      .push_valid (step_valid),
      .push_item  (step_item)
   );

   assign state_in   = accept ? step_state : state_ff;
   assign push_valid = accept ? step_valid : 2'b00;
   assign cover_in   = (csr_valid && csr_ready) ? csr_data : cover_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR_STATE;
         cover_ff <= COVER_RESET;
      end else begin
         state_ff <= state_in;
         cover_ff <= cover_in;
      end
   end

   // output queue parts the decoder from a stalled receiver
   x64ilb_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (step_item),
      .room_two   (room_two),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (head_item)
   );

   assign rsp_tlast = head_item.is_summary;
   assign rsp_tdata = {7'd0, head_item.overwrite_bytes, head_item.instr_total,
                       head_item.plan_reloc_safe, head_item.decode_ok,
                       head_item.instr_reloc_safe, head_item.instr_length};

   a_summary_shows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> rsp_tvalid)
      else $error("window end gave no result");

   a_count_budget: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= 5'(MAX_INSTRUCTIONS))
      else $error("instruction count beyond budget");

   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.pos <= 5'(POS_LIMIT))
      else $error("window position beyond limit");

endmodule
